// File: sv/pcmd_pkg.sv
// Package for the PTZ command message decoder.
// Holds the action codes, message framing constants and the byte position state type.
// No dependencies.
package pcmd_pkg;

   // Number of protocol bytes in one command message.
   localparam int unsigned MESSAGE_BYTES = 3;

   // Register index of the full speed register.
   localparam logic REG_FULL_SPEED = 1'b0;

   // Reset value of the full speed register.
   localparam logic [10:0] FULL_SPEED_RESET = 11'd2047;

   // Action codes reported on the result channel.
   localparam logic [3:0] ACT_NONE       = 4'd0;
   localparam logic [3:0] ACT_PAN_L      = 4'd1;
   localparam logic [3:0] ACT_PAN_R      = 4'd2;
   localparam logic [3:0] ACT_TILT_D     = 4'd3;
   localparam logic [3:0] ACT_TILT_U     = 4'd4;
   localparam logic [3:0] ACT_ZOOM_IN    = 4'd5;
   localparam logic [3:0] ACT_ZOOM_OUT   = 4'd6;
   localparam logic [3:0] ACT_FOC_FAR    = 4'd7;
   localparam logic [3:0] ACT_FOC_NEAR   = 4'd8;
   localparam logic [3:0] ACT_IRIS_OPEN  = 4'd9;
   localparam logic [3:0] ACT_IRIS_CLOSE = 4'd10;
   localparam logic [3:0] ACT_CAM_OFF    = 4'd11;
   localparam logic [3:0] ACT_CAM_ON     = 4'd12;
   localparam logic [3:0] ACT_WIPER      = 4'd13;
   localparam logic [3:0] ACT_RECALL     = 4'd14;
   localparam logic [3:0] ACT_STORE      = 4'd15;

   // Command field values of the second byte.
   localparam logic [1:0] CMD_LENS   = 2'd0;
   localparam logic [1:0] CMD_AUX    = 2'd1;
   localparam logic [1:0] CMD_RECALL = 2'd2;
   localparam logic [1:0] CMD_STORE  = 2'd3;

   // Extra field value that selects full speed on a pan/tilt command.
   localparam logic [2:0] EXTRA_FULL = 3'd7;

   // Position within a message, one-hot.
   typedef enum logic [2:0] {
      POS_FIRST  = 3'b001,
      POS_SECOND = 3'b010,
      POS_THIRD  = 3'b100
   } byte_pos_type;

endpackage

// File: sv/pcmd_stream_if.sv
// Handshake channel interfaces of the PTZ command message decoder.
// pcmd_req_if carries received bytes, pcmd_rsp_if carries decoded commands.
// No dependencies.
interface pcmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface pcmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] receiver;
   logic        receiver_changed;
   logic [3:0]  action;
   logic [10:0] speed;
   logic [3:0]  preset;

   modport source (output valid, output receiver, output receiver_changed,
                   output action, output speed, output preset, input ready);
   modport sink (input valid, input receiver, input receiver_changed,
                 input action, input speed, input preset, output ready);
endinterface

// File: sv/pcmd_csr.sv
// Configuration register block of the PTZ command message decoder.
// APB-style write and read of the full speed register; uses pcmd_pkg.
module pcmd_csr import pcmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [10:0] full_speed
);

   logic [10:0] full_speed_ff;
   logic [10:0] full_speed_in;
   logic        reg_index;
   logic        write_en;

   // The register index is the word address.
   assign reg_index = paddr[2];
   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite && pready;

   // Register update on a completed write transaction.
   always_comb begin
      full_speed_in = full_speed_ff;
      if (write_en && (reg_index == REG_FULL_SPEED)) begin
         full_speed_in = pwdata[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_speed_ff <= FULL_SPEED_RESET;
      end else begin
         full_speed_ff <= full_speed_in;
      end
   end

   // Read data; addresses beyond the register read as zero.
   always_comb begin
      prdata = 32'd0;
      if (reg_index == REG_FULL_SPEED) begin
         prdata = {21'd0, full_speed_ff};
      end
   end

   assign full_speed = full_speed_ff;

endmodule

// File: sv/pcmd_decode.sv
// Message assembly and command decode of the PTZ command message decoder.
// Collects three bytes and registers one decoded command; uses pcmd_pkg and the channel interfaces.
module pcmd_decode import pcmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [10:0] full_speed,
   pcmd_req_if.sink    req,
   pcmd_rsp_if.source  rsp
);

   byte_pos_type pos_ff, pos_in;
   logic [7:0]   first_byte_ff, first_byte_in;
   logic [7:0]   second_byte_ff, second_byte_in;
   logic [10:0]  last_receiver_ff, last_receiver_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [10:0]  receiver_ff, receiver_in;
   logic         changed_ff, changed_in;
   logic [3:0]   action_ff, action_in;
   logic [10:0]  speed_ff, speed_in;
   logic [3:0]   preset_ff, preset_in;

   logic         accept;
   logic         complete;
   logic [1:0]   cmd;
   logic [2:0]   extra;
   logic [10:0]  recv;
   logic [3:0]   dec_action;
   logic [10:0]  dec_speed;
   logic [3:0]   dec_preset;

   // A byte is taken whenever the result register is empty or is being emptied.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign complete  = accept && (pos_ff == POS_THIRD);

   // Byte position tracking; a first byte without bit 7 is dropped.
   always_comb begin
      pos_in         = pos_ff;
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      if (accept) begin
         unique case (pos_ff)
            POS_FIRST: begin
               if (req.rx_byte[7]) begin
                  first_byte_in = req.rx_byte;
                  pos_in        = POS_SECOND;
               end
            end
            POS_SECOND: begin
               second_byte_in = req.rx_byte;
               pos_in         = POS_THIRD;
            end
            POS_THIRD: begin
               pos_in = POS_FIRST;
            end
            default: begin
               pos_in = POS_FIRST;
            end
         endcase
      end
   end

   // Field extraction from the held bytes and the incoming third byte.
   assign cmd   = second_byte_ff[5:4];
   assign extra = second_byte_ff[3:1];
   assign recv  = 11'd1 + {1'b0, first_byte_ff[3:0], second_byte_ff[0], req.rx_byte[6:2]};

   // Command decode.
   always_comb begin
      dec_action = ACT_NONE;
      dec_speed  = 11'd0;
      dec_preset = 4'd0;
      if (req.rx_byte[1]) begin
         // Pan/tilt command with a stepped speed.
         case (cmd)
            2'd0:    dec_action = ACT_TILT_D;
            2'd1:    dec_action = ACT_TILT_U;
            2'd2:    dec_action = ACT_PAN_L;
            default: dec_action = ACT_PAN_R;
         endcase
         if (extra == EXTRA_FULL) begin
            dec_speed = full_speed;
         end else begin
            dec_speed = {3'(extra + 3'd1), 8'h00};
         end
      end else begin
         unique case (cmd)
            CMD_LENS: begin
               case (extra)
                  3'd0:    dec_action = ACT_TILT_D;
                  3'd1:    dec_action = ACT_IRIS_OPEN;
                  3'd2:    dec_action = ACT_FOC_FAR;
                  3'd3:    dec_action = ACT_ZOOM_IN;
                  3'd4:    dec_action = ACT_IRIS_CLOSE;
                  3'd5:    dec_action = ACT_FOC_NEAR;
                  3'd6:    dec_action = ACT_ZOOM_OUT;
                  default: dec_action = ACT_PAN_L;
               endcase
               if ((extra == 3'd0) || (extra == 3'd7)) begin
                  dec_speed = full_speed;
               end
            end
            CMD_AUX: begin
               // Unused aux codes still give a result, with no action.
               case (extra)
                  3'd0:    dec_action = ACT_TILT_U;
                  3'd1:    dec_action = ACT_PAN_R;
                  3'd2:    dec_action = ACT_CAM_OFF;
                  3'd3:    dec_action = ACT_CAM_ON;
                  3'd7:    dec_action = ACT_WIPER;
                  default: dec_action = ACT_NONE;
               endcase
               if ((extra == 3'd0) || (extra == 3'd1)) begin
                  dec_speed = full_speed;
               end
            end
            CMD_RECALL: begin
               dec_action = ACT_RECALL;
               dec_preset = {1'b0, extra} + 4'd1;
            end
            CMD_STORE: begin
               dec_action = ACT_STORE;
               dec_preset = {1'b0, extra} + 4'd1;
            end
            default: begin
               dec_action = ACT_NONE;
            end
         endcase
      end
   end

   // Result register and last receiver update.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      receiver_in      = receiver_ff;
      changed_in       = changed_ff;
      action_in        = action_ff;
      speed_in         = speed_ff;
      preset_in        = preset_ff;
      last_receiver_in = last_receiver_ff;
      if (complete) begin
         rsp_valid_in     = 1'b1;
         receiver_in      = recv;
         changed_in       = (recv != last_receiver_ff);
         action_in        = dec_action;
         speed_in         = dec_speed;
         preset_in        = dec_preset;
         last_receiver_in = recv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= POS_FIRST;
         first_byte_ff    <= 8'd0;
         second_byte_ff   <= 8'd0;
         last_receiver_ff <= 11'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         first_byte_ff    <= first_byte_in;
         second_byte_ff   <= second_byte_in;
         last_receiver_ff <= last_receiver_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      receiver_ff <= receiver_in;
      changed_ff  <= changed_in;
      action_ff   <= action_in;
      speed_ff    <= speed_in;
      preset_ff   <= preset_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.receiver         = receiver_ff;
   assign rsp.receiver_changed = changed_ff;
   assign rsp.action           = action_ff;
   assign rsp.speed            = speed_ff;
   assign rsp.preset           = preset_ff;

endmodule

// File: sv/ptz_command_message_decoder_top.sv
// Top level of the PTZ command message decoder.
// Instantiates pcmd_csr and pcmd_decode; uses pcmd_pkg and the channel interfaces.
//
//   Channel   Direction  Transaction
//   req       in         one received protocol byte (rx_byte)
//   rsp       out        one decoded command per completed three-byte message
//   csr_      in/out     APB-style access to the full speed register
//
// One byte is accepted every cycle while req.ready is high; a completed message
// appears on rsp in the cycle after its third byte, through a single result register.
// The input stays ready while a result waits, as long as rsp.ready takes it in
// the same cycle; only a result held under back-pressure stalls req.
// Reset is synchronous and returns the block to waiting for a first byte,
// with no previous receiver and full speed at 2047.
module ptz_command_message_decoder_top import pcmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pcmd_req_if.sink    req,
   pcmd_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [10:0] full_speed;

   // Configuration register.
   pcmd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .full_speed (full_speed)
   );

   // Message assembly and decode.
   pcmd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .full_speed (full_speed),
      .req        (req),
      .rsp        (rsp)
   );

   // With no result pending the block must take the next byte.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("req not ready while result register empty");

   // A decoded receiver address is never zero.
   a_receiver_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.receiver != 11'd0))
      else $error("decoded receiver address is zero");

   // A speed is only reported with a pan or tilt action.
   a_speed_action: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.speed != 11'd0)) |->
         ((rsp.action == ACT_PAN_L) || (rsp.action == ACT_PAN_R) ||
          (rsp.action == ACT_TILT_D) || (rsp.action == ACT_TILT_U)))
      else $error("speed reported without pan or tilt action");

   // A preset is reported exactly with recall and store.
   a_preset_action: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |->
         ((rsp.preset != 4'd0) ==
          ((rsp.action == ACT_RECALL) || (rsp.action == ACT_STORE))))
      else $error("preset and action disagree");

endmodule
